[hw/rtl/sitda_pkg.sv]
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared types and constants for the signed integer to decimal text block.
// ----------------------------------------------------------------------------
package sitda_pkg;

    localparam int VALUE_W    = 32;
    localparam int CHAR_W     = 7;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4 * NUM_DIGITS;

    localparam logic [CHAR_W-1:0] DIGIT_BASE_CODE = 7'd48;
    localparam logic [CHAR_W-1:0] MINUS_CODE      = 7'd45;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SKIP,
        S_SIGN,
        S_EMIT
    } t_state;

endpackage

[hw/rtl/signed_int_to_decimal_ascii.sv]
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts the magnitude by shift-add-3 over all 32 bits, then drops leading zeros,
// after which one character is strobed per cycle, sign first.
// A new request is taken only while idle, after the last character has been strobed;
// the shared add-3/shift unit over 32 bits is busy with one conversion at a time.
// The receiver cannot stall: each character is strobed for one cycle only.
// Reset: synchronous, active low; returns to idle and drops any request.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [sitda_pkg::VALUE_W-1:0] i_value,
    output logic                              o_busy,
    output logic                              o_strobe,
    output logic        [sitda_pkg::CHAR_W-1:0]  o_char_code,
    output logic                              o_last
);
    import sitda_pkg::*;

    t_state               r_state, n_state;
    logic                 r_neg, n_neg;
    logic [VALUE_W-1:0]   r_bin, n_bin;
    logic [BCD_W-1:0]     r_bcd, n_bcd;
    logic [4:0]           r_iter, n_iter;
    logic [3:0]           r_ndig, n_ndig;
    logic [BCD_W-1:0]     w_adj;
    logic [VALUE_W-1:0]   w_raw;
    logic                 w_accept;

    assign w_raw    = VALUE_W'(i_value);
    assign w_accept = i_start && !o_busy;
    assign o_busy   = (r_state != S_IDLE);

    always_comb begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (r_bcd[4*d +: 4] >= 4'd5) begin
                w_adj[4*d +: 4] = r_bcd[4*d +: 4] + 4'd3;
            end else begin
                w_adj[4*d +: 4] = r_bcd[4*d +: 4];
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_neg       = r_neg;
        n_bin       = r_bin;
        n_bcd       = r_bcd;
        n_iter      = r_iter;
        n_ndig      = r_ndig;
        o_strobe    = 1'b0;
        o_char_code = MINUS_CODE;
        o_last      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_neg   = w_raw[VALUE_W-1];
                    n_bin   = w_raw[VALUE_W-1] ? (VALUE_W'(0) - w_raw) : w_raw;
                    n_bcd   = '0;
                    n_iter  = '0;
                    n_ndig  = 4'(NUM_DIGITS);
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                n_bcd  = {w_adj[BCD_W-2:0], r_bin[VALUE_W-1]};
                n_bin  = {r_bin[VALUE_W-2:0], 1'b0};
                n_iter = r_iter + 5'd1;
                if (r_iter == 5'(VALUE_W - 1)) begin
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                // drop leading zeros, keep at least one digit
                if (r_bcd[BCD_W-1 -: 4] == 4'd0 && r_ndig != 4'd1) begin
                    n_bcd  = {r_bcd[BCD_W-5:0], 4'd0};
                    n_ndig = r_ndig - 4'd1;
                end else begin
                    n_state = r_neg ? S_SIGN : S_EMIT;
                end
            end
            S_SIGN: begin
                o_strobe    = 1'b1;
                o_char_code = MINUS_CODE;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                o_strobe    = 1'b1;
                o_char_code = DIGIT_BASE_CODE + {3'b000, r_bcd[BCD_W-1 -: 4]};
                o_last      = (r_ndig == 4'd1);
                n_bcd       = {r_bcd[BCD_W-5:0], 4'd0};
                n_ndig      = r_ndig - 4'd1;
                if (r_ndig == 4'd1) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_iter  <= '0;
            r_ndig  <= '0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
            r_ndig  <= n_ndig;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg <= n_neg;
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_busy)
        else $error("strobe while idle");

    a_last_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> o_strobe)
        else $error("last without strobe");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |=> !o_busy)
        else $error("busy after last character");

    a_run_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |=> o_strobe)
        else $error("gap inside character run");

    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy && !o_strobe))
        else $error("request not taken up");

endmodule
